### hdl/multichannel_length_prefixed_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
// MLPD_ASSERT checks a property on every clock edge outside reset.
// MLPD_ASSERT_NEVER checks that a condition never holds outside reset.
`ifndef MULTICHANNEL_LENGTH_PREFIXED_DEFRAMER_CORE_DEFINES_SVH
`define MULTICHANNEL_LENGTH_PREFIXED_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MLPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MLPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MLPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hdl/mlpd_pkg.sv
package mlpd_pkg;

  // Item kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // Frame start marker '<'
  localparam logic [7:0] START_BYTE = 8'h3C;

  localparam int unsigned CH_FIELD_W = 2;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned DLEN_W     = 9;

  // One input item
  typedef struct packed {
    logic                  kind;
    logic [CH_FIELD_W-1:0] channel;
    logic [7:0]            rx_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [7:0]            payload_byte;
    logic [LEN_W-1:0]      position;
    logic                  kept;
    logic                  frame_end;
    logic [DLEN_W-1:0]     delivered_length;
  } result_t;

endpackage

### hdl/mlpd_in_stage.sv
module mlpd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mlpd_pkg::item_t in_item,
  input  logic            take,
  output logic            vld,
  output mlpd_pkg::item_t item
);

  logic            vld_r;
  logic            vld_nxt;
  mlpd_pkg::item_t item_r;
  logic            load;

  // Hold the registered item until the parser takes it
  assign in_stall = vld_r && !take;
  assign load     = !in_stall;
  assign vld_nxt  = load ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture the payload on every transfer slot
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

### hdl/mlpd_parser.sv
`include "multichannel_length_prefixed_deframer_core_defines.svh"

module mlpd_parser #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld,
  input  mlpd_pkg::item_t   item,
  input  logic              out_blocked,
  output logic              take,
  output logic              res_load,
  output mlpd_pkg::result_t res
);

  // Only four channels are addressable through the channel field
  localparam int unsigned NCH  = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int unsigned CH_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned LW   = mlpd_pkg::LEN_W;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_START   = 4'b0010,
    PH_LENLO   = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  phase_t        ph_r  [NCH];
  logic [LW-1:0] len_r [NCH];
  logic [LW-1:0] cnt_r [NCH];

  logic          ch_ok;
  logic [CH_W-1:0] idx;
  phase_t        cur_ph;
  logic [LW-1:0] cur_len;
  logic [LW-1:0] cur_cnt;
  phase_t        ph_nxt;
  logic [LW-1:0] len_nxt;
  logic [LW-1:0] cnt_nxt;
  logic [LW-1:0] len_full;
  logic [LW:0]   pos_inc;
  logic          is_end;
  logic          is_kept;
  logic [LW-1:0] dl_full;
  logic          produce;
  logic          upd;

  // Look up the addressed channel
  assign ch_ok   = (int'(item.channel) < NCH);
  assign idx     = CH_W'(item.channel);
  assign cur_ph  = ph_r[idx];
  assign cur_len = len_r[idx];
  assign cur_cnt = cnt_r[idx];

  // Payload byte arithmetic
  assign pos_inc  = {1'b0, cur_cnt} + {{LW{1'b0}}, 1'b1};
  assign is_end   = (pos_inc >= {1'b0, cur_len});
  assign is_kept  = ({1'b0, cur_cnt} < (LW+1)'(MAX_FRAME));
  assign dl_full  = (cur_len > LW'(MAX_FRAME)) ? LW'(MAX_FRAME) : cur_len;
  assign len_full = {item.rx_byte, cur_len[7:0]};

  assign produce = ch_ok && (item.kind == mlpd_pkg::KIND_BYTE) && (cur_ph == PH_PAYLOAD);

  // Advance unless a result would land on a stalled output
  assign take     = vld && !(produce && out_blocked);
  assign res_load = take && produce;
  assign upd      = take && ch_ok;

  // Next state of the addressed channel
  always_comb begin
    ph_nxt  = cur_ph;
    len_nxt = cur_len;
    cnt_nxt = cur_cnt;
    if (item.kind == mlpd_pkg::KIND_RESET) begin
      ph_nxt  = PH_HUNT;
      len_nxt = '0;
      cnt_nxt = '0;
    end else begin
      case (cur_ph)
        PH_HUNT: begin
          if (item.rx_byte == mlpd_pkg::START_BYTE) begin
            ph_nxt = PH_START;
          end
        end
        PH_START: begin
          len_nxt = {8'h00, item.rx_byte};
          ph_nxt  = PH_LENLO;
        end
        PH_LENLO: begin
          len_nxt = len_full;
          cnt_nxt = '0;
          ph_nxt  = (len_full != '0) ? PH_PAYLOAD : PH_HUNT;
        end
        PH_PAYLOAD: begin
          cnt_nxt = pos_inc[LW-1:0];
          if (is_end) begin
            ph_nxt = PH_HUNT;
          end
        end
        default: begin
          ph_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Channel state table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        ph_r[i]  <= PH_HUNT;
        len_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (upd) begin
      ph_r[idx]  <= ph_nxt;
      len_r[idx] <= len_nxt;
      cnt_r[idx] <= cnt_nxt;
    end
  end

  // Result fields for the output register
  always_comb begin
    res.channel          = item.channel;
    res.payload_byte     = item.rx_byte;
    res.position         = cur_cnt;
    res.kept             = is_kept;
    res.frame_end        = is_end;
    res.delivered_length = is_end ? dl_full[mlpd_pkg::DLEN_W-1:0] : '0;
  end

  `MLPD_ASSERT(a_reset_item_hunts, clk, rst_n, (upd && item.kind == mlpd_pkg::KIND_RESET) |=> (ph_r[$past(idx)] == PH_HUNT), "reset item did not return channel to hunting")
  `MLPD_ASSERT(a_payload_len_nonzero, clk, rst_n, (ch_ok && cur_ph == PH_PAYLOAD) |-> (cur_len != '0), "payload phase entered with zero length")
  `MLPD_ASSERT(a_count_below_len, clk, rst_n, (ch_ok && cur_ph == PH_PAYLOAD) |-> (cur_cnt < cur_len), "received count reached declared length inside a frame")

endmodule

### hdl/mlpd_out_stage.sv
module mlpd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_load,
  input  mlpd_pkg::result_t res,
  output logic              blocked,
  output logic              out_valid,
  input  logic              out_stall,
  output mlpd_pkg::result_t out_res
);

  logic              vld_r;
  logic              vld_nxt;
  mlpd_pkg::result_t res_r;

  assign blocked = vld_r && out_stall;

  // Load a new result, drop the old one once transferred
  always_comb begin
    vld_nxt = vld_r;
    if (res_load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

### hdl/multichannel_length_prefixed_deframer_core.sv
// Per-channel deframer for up to four interleaved client byte streams.
// Input channel: in_valid/in_stall with in_kind, in_channel and in_rx_byte.
// A byte item advances the addressed channel's parser: hunt for '<', take a
// 16-bit little-endian length, then emit one result per payload byte. A reset
// item returns that channel to hunting and gives no result.
// Result channel: out_valid/out_stall with channel, byte, position, kept flag,
// frame_end and the delivered length (clamped to MAX_FRAME) on the last byte.
// Each item passes an input register, a state lookup and update, and a
// result register, which offers the result. One item is taken every cycle
// while no payload byte waits behind a stalled result; the channel state
// table is read and written in the same cycle, so items for the same
// channel may follow each other with no gap.
// When the receiver stalls, the held result blocks only the next payload
// byte; header and reset items keep flowing. in_stall rises only while a
// payload byte waits behind a stalled result.
// Synchronous reset puts every channel into hunting with zero length and
// count, and empties both registers.
`include "multichannel_length_prefixed_deframer_core_defines.svh"

module multichannel_length_prefixed_deframer_core #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [mlpd_pkg::CH_FIELD_W-1:0] in_channel,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mlpd_pkg::CH_FIELD_W-1:0] out_channel,
  output logic [7:0]                      out_payload_byte,
  output logic [mlpd_pkg::LEN_W-1:0]      out_position,
  output logic                            out_kept,
  output logic                            out_frame_end,
  output logic [mlpd_pkg::DLEN_W-1:0]     out_delivered_length
);

  mlpd_pkg::item_t   in_item;
  mlpd_pkg::item_t   item;
  logic              item_vld;
  logic              take;
  logic              res_load;
  logic              blocked;
  mlpd_pkg::result_t res;
  mlpd_pkg::result_t out_res;

  assign in_item.kind    = in_kind;
  assign in_item.channel = in_channel;
  assign in_item.rx_byte = in_rx_byte;

  mlpd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .vld      (item_vld),
    .item     (item)
  );

  mlpd_parser #(
    .CHANNELS  (CHANNELS),
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld         (item_vld),
    .item        (item),
    .out_blocked (blocked),
    .take        (take),
    .res_load    (res_load),
    .res         (res)
  );

  mlpd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .blocked   (blocked),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_channel          = out_res.channel;
  assign out_payload_byte     = out_res.payload_byte;
  assign out_position         = out_res.position;
  assign out_kept             = out_res.kept;
  assign out_frame_end        = out_res.frame_end;
  assign out_delivered_length = out_res.delivered_length;

  `MLPD_ASSERT(a_stall_needs_blocked_out, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled while the result register was free")
  `MLPD_ASSERT_NEVER(a_len_only_at_end, clk, rst_n, out_valid && !out_frame_end && (out_delivered_length != '0), "delivered length set on a byte that is not the last")
  `MLPD_ASSERT(a_kept_below_max, clk, rst_n, (out_valid && out_kept) |-> ({1'b0, out_position} < (mlpd_pkg::LEN_W+1)'(MAX_FRAME)), "byte marked kept beyond the frame limit")

endmodule

### tb/sv/deframe_checker.sv
module deframe_checker #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_kind,
  input  logic [mlpd_pkg::CH_FIELD_W-1:0] in_channel,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [mlpd_pkg::CH_FIELD_W-1:0] out_channel,
  input  logic [7:0]                      out_payload_byte,
  input  logic [mlpd_pkg::LEN_W-1:0]      out_position,
  input  logic                            out_kept,
  input  logic                            out_frame_end,
  input  logic [mlpd_pkg::DLEN_W-1:0]     out_delivered_length,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    HUNTING         = 4'b0001,
    START_SEEN      = 4'b0010,
    LENGTH_LOW_SEEN = 4'b0100,
    IN_PAYLOAD      = 4'b1000
  } parse_phase_t;

  // Per-channel parser state of the predictor
  parse_phase_t                 parse_phase  [CHANNELS];
  logic [mlpd_pkg::LEN_W-1:0]   frame_length [CHANNELS];
  logic [mlpd_pkg::LEN_W-1:0]   byte_count   [CHANNELS];

  mlpd_pkg::result_t expected_bytes [$];
  int                errors = 0;

  assign fail_count = errors;

  // Advance one channel's parser; return 1 when the byte is payload
  function automatic bit deframe_step(input mlpd_pkg::item_t it,
                                      output mlpd_pkg::result_t res);
    int unsigned ch;
    int unsigned pos;
    int unsigned len;
    bit          closes_frame;
    ch  = 32'(it.channel);
    res = '0;
    if (ch >= CHANNELS) return 1'b0;
    if (it.kind == mlpd_pkg::KIND_RESET) begin
      parse_phase[ch]  = HUNTING;
      frame_length[ch] = '0;
      byte_count[ch]   = '0;
      return 1'b0;
    end
    case (parse_phase[ch])
      HUNTING: begin
        if (it.rx_byte == mlpd_pkg::START_BYTE) parse_phase[ch] = START_SEEN;
        return 1'b0;
      end
      START_SEEN: begin
        frame_length[ch] = {8'h00, it.rx_byte};
        parse_phase[ch]  = LENGTH_LOW_SEEN;
        return 1'b0;
      end
      LENGTH_LOW_SEEN: begin
        frame_length[ch][15:8] = it.rx_byte;
        byte_count[ch]         = '0;
        if (frame_length[ch] != '0) parse_phase[ch] = IN_PAYLOAD;
        else parse_phase[ch] = HUNTING;
        return 1'b0;
      end
      default: ;
    endcase
    // Payload byte: emit it with its position, close the frame on the last one
    pos            = 32'(byte_count[ch]);
    len            = 32'(frame_length[ch]);
    closes_frame   = (pos + 1) >= len;
    byte_count[ch] = mlpd_pkg::LEN_W'(pos + 1);
    res.channel      = it.channel;
    res.payload_byte = it.rx_byte;
    res.position     = mlpd_pkg::LEN_W'(pos);
    res.kept         = pos < MAX_FRAME;
    res.frame_end    = closes_frame;
    if (closes_frame) begin
      res.delivered_length = mlpd_pkg::DLEN_W'((len > MAX_FRAME) ? MAX_FRAME : len);
      parse_phase[ch]      = HUNTING;
    end
    return 1'b1;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each result transfer, then predict from each input transfer
  always @(posedge clk) begin
    mlpd_pkg::item_t   taken;
    mlpd_pkg::result_t want;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        parse_phase[i]  = HUNTING;
        frame_length[i] = '0;
        byte_count[i]   = '0;
      end
      expected_bytes.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual channel %0d byte %0d pos %0d",
                   $time, out_channel, out_payload_byte, out_position);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          compare_field("channel", 32'(want.channel), 32'(out_channel));
          compare_field("payload_byte", 32'(want.payload_byte), 32'(out_payload_byte));
          compare_field("position", 32'(want.position), 32'(out_position));
          compare_field("kept", 32'(want.kept), 32'(out_kept));
          compare_field("frame_end", 32'(want.frame_end), 32'(out_frame_end));
          compare_field("delivered_length", 32'(want.delivered_length),
                        32'(out_delivered_length));
        end
      end
      if (in_valid && !in_stall) begin
        taken.kind    = in_kind;
        taken.channel = in_channel;
        taken.rx_byte = in_rx_byte;
        if (deframe_step(taken, want)) expected_bytes.push_back(want);
      end
      pending <= expected_bytes.size();
    end
  end

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHANNELS         = 4;
  localparam int unsigned MAX_FRAME        = 256;
  localparam int unsigned ITEM_TARGET      = 700;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES    = 20;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_kind;
  logic [mlpd_pkg::CH_FIELD_W-1:0] in_channel;
  logic [7:0]                      in_rx_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [mlpd_pkg::CH_FIELD_W-1:0] out_channel;
  logic [7:0]                      out_payload_byte;
  logic [mlpd_pkg::LEN_W-1:0]      out_position;
  logic                            out_kept;
  logic                            out_frame_end;
  logic [mlpd_pkg::DLEN_W-1:0]     out_delivered_length;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned long_frames = 0;
  bit          full_frame_done = 1'b0;
  bit          tx_idle = 1'b1;
  bit          rx_idle;
  bit          hold_request;

  mlpd_pkg::item_t channel_script [CHANNELS][$];

  multichannel_length_prefixed_deframer_core #(
    .CHANNELS (CHANNELS),
    .MAX_FRAME(MAX_FRAME)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_channel          (in_channel),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel         (out_channel),
    .out_payload_byte    (out_payload_byte),
    .out_position        (out_position),
    .out_kept            (out_kept),
    .out_frame_end       (out_frame_end),
    .out_delivered_length(out_delivered_length)
  );

  deframe_checker #(
    .CHANNELS (CHANNELS),
    .MAX_FRAME(MAX_FRAME)
  ) deframe_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_channel          (in_channel),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel         (out_channel),
    .out_payload_byte    (out_payload_byte),
    .out_position        (out_position),
    .out_kept            (out_kept),
    .out_frame_end       (out_frame_end),
    .out_delivered_length(out_delivered_length),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall after each transfer while rx_idle is set, plus one long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (out_valid && !out_stall) stall_left = rx_idle ? $urandom_range(0, 5) : 0;
      else if (stall_left != 0) stall_left--;
      if (hold_left != 0) hold_left--;
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  function automatic mlpd_pkg::item_t make_item(logic kind, int unsigned ch, logic [7:0] b);
    mlpd_pkg::item_t it;
    it.kind    = kind;
    it.channel = mlpd_pkg::CH_FIELD_W'(ch);
    it.rx_byte = b;
    return it;
  endfunction

  // Offer one item, after a random gap when tx_idle is set, and hold it until it transfers
  task automatic send_item(input mlpd_pkg::item_t it);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= it.kind;
    in_channel <= it.channel;
    in_rx_byte <= it.rx_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and hold until every expected payload byte has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Queue the next stretch of traffic for one channel
  function automatic void plan_channel(int unsigned ch);
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      // Well-formed frame, maybe after some junk that holds no start byte
      repeat ($urandom_range(0, 2)) begin
        b = 8'($urandom);
        if (b == mlpd_pkg::START_BYTE) b ^= 8'h01;
        channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, b));
      end
      if (long_frames == 0 && items_sent > 300) begin
        len = $urandom_range(MAX_FRAME + 1, MAX_FRAME + 4);
        long_frames++;
      end else if (!full_frame_done && items_sent > 150) begin
        len = MAX_FRAME;
        full_frame_done = 1'b1;
      end else begin
        len = $urandom_range(1, 16);
      end
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, mlpd_pkg::START_BYTE));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, len[7:0]));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, len[15:8]));
      repeat (len)
        channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, 8'($urandom)));
    end else if (pick < 80) begin
      // Zero-length header
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, mlpd_pkg::START_BYTE));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, 8'h00));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, 8'h00));
    end else if (pick < 90) begin
      // Huge declared length, cut short by a channel reset
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, mlpd_pkg::START_BYTE));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, 8'($urandom)));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch,
                                             8'($urandom_range(1, 255))));
      repeat ($urandom_range(0, 4))
        channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, 8'($urandom)));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_RESET, ch, 8'($urandom)));
    end else begin
      // Raw noise, then a reset to drop whatever it started
      repeat ($urandom_range(1, 4))
        channel_script[ch].push_back(make_item(mlpd_pkg::KIND_BYTE, ch, 8'($urandom)));
      channel_script[ch].push_back(make_item(mlpd_pkg::KIND_RESET, ch, 8'($urandom)));
    end
  endfunction

  initial begin
    int unsigned ch;
    int unsigned mode;
    bit          hold_asked;
    bit          drained;
    hold_asked   = 1'b0;
    drained      = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= mlpd_pkg::KIND_BYTE;
    in_channel   <= '0;
    in_rx_byte   <= '0;
    rx_idle      <= 1'b1;
    hold_request <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hunting junk, zero length, then a one-byte frame
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, 8'h00));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, 8'hFF));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, mlpd_pkg::START_BYTE));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, 8'h00));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, 8'h00));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, mlpd_pkg::START_BYTE));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, 8'h01));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, 8'h00));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 0, 8'hFF));
    // Interleaved channels: start byte inside a payload, huge length cut by reset
    send_item(make_item(mlpd_pkg::KIND_BYTE, 1, mlpd_pkg::START_BYTE));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 1, 8'h03));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 2, mlpd_pkg::START_BYTE));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 1, 8'h00));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 2, 8'hFF));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 1, mlpd_pkg::START_BYTE));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 2, 8'hFF));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 1, 8'h55));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 2, 8'h81));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 1, 8'hAA));
    send_item(make_item(mlpd_pkg::KIND_RESET, 2, 8'hFF));
    send_item(make_item(mlpd_pkg::KIND_RESET, 3, 8'h00));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 3, mlpd_pkg::START_BYTE));
    send_item(make_item(mlpd_pkg::KIND_RESET, 3, 8'h3C));
    send_item(make_item(mlpd_pkg::KIND_BYTE, 2, 8'h7E));

    // Random interleaved traffic; idling mode steps every hundred items
    while (items_sent < ITEM_TARGET) begin
      mode    = (items_sent / 100) % 4;
      tx_idle = mode[0];
      rx_idle <= !mode[1];
      if (!hold_asked && items_sent >= 200) begin
        hold_asked = 1'b1;
        hold_request <= 1'b1;
      end
      if (!drained && items_sent >= 450) begin
        drained = 1'b1;
        wait_for_drain();
      end
      ch = $urandom_range(0, CHANNELS - 1);
      if (channel_script[ch].size() == 0) plan_channel(ch);
      send_item(channel_script[ch].pop_front());
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
